// File: hw/rtl/vppi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vppi_pkg
// Shared types and codes of the video processor port interface: port command
// codes, register indexes, update kinds and the result record.
// ----------------------------------------------------------------------------
package vppi_pkg;

	// Default width of the video memory address counter.
	localparam int VRAM_ADDR_BITS_DEF = 17;

	// Port command codes.
	localparam logic [1:0] CMD_DATA    = 2'd0;
	localparam logic [1:0] CMD_CONTROL = 2'd1;
	localparam logic [1:0] CMD_PALETTE = 2'd2;

	// Register indexes with a derived quantity.
	localparam logic [5:0] REG_MODE0    = 6'h00;
	localparam logic [5:0] REG_MODE1    = 6'h01;
	localparam logic [5:0] REG_NAME     = 6'h02;
	localparam logic [5:0] REG_COLOR    = 6'h03;
	localparam logic [5:0] REG_PATTERN  = 6'h04;
	localparam logic [5:0] REG_SPR_ATTR = 6'h05;
	localparam logic [5:0] REG_SPR_PAT  = 6'h06;
	localparam logic [5:0] REG_BORDER   = 6'h07;
	localparam logic [5:0] REG_LINES    = 6'h09;
	localparam logic [5:0] REG_SPR_COL  = 6'h0b;
	localparam logic [5:0] REG_ADDR_HI  = 6'h0e;
	localparam logic [5:0] REG_PAL_PTR  = 6'h10;
	localparam logic [5:0] REG_SX_LO    = 6'h20;
	localparam logic [5:0] REG_SX_HI    = 6'h21;
	localparam logic [5:0] REG_SY_LO    = 6'h22;
	localparam logic [5:0] REG_SY_HI    = 6'h23;
	localparam logic [5:0] REG_DX_LO    = 6'h24;
	localparam logic [5:0] REG_DX_HI    = 6'h25;
	localparam logic [5:0] REG_DY_LO    = 6'h26;
	localparam logic [5:0] REG_DY_HI    = 6'h27;
	localparam logic [5:0] REG_NX_LO    = 6'h28;
	localparam logic [5:0] REG_NX_HI    = 6'h29;
	localparam logic [5:0] REG_NY_LO    = 6'h2a;
	localparam logic [5:0] REG_NY_HI    = 6'h2b;

	// Update kinds.
	localparam logic [4:0] KIND_NONE     = 5'd0;
	localparam logic [4:0] KIND_MODE     = 5'd1;
	localparam logic [4:0] KIND_NAME     = 5'd2;
	localparam logic [4:0] KIND_COLOR    = 5'd3;
	localparam logic [4:0] KIND_PATTERN  = 5'd4;
	localparam logic [4:0] KIND_SPR_ATTR = 5'd5;
	localparam logic [4:0] KIND_SPR_PAT  = 5'd6;
	localparam logic [4:0] KIND_BORDER   = 5'd7;
	localparam logic [4:0] KIND_LINES    = 5'd8;
	localparam logic [4:0] KIND_SPR_COL  = 5'd9;
	localparam logic [4:0] KIND_SRC_X    = 5'd10;
	localparam logic [4:0] KIND_SRC_Y    = 5'd11;
	localparam logic [4:0] KIND_DST_X    = 5'd12;
	localparam logic [4:0] KIND_DST_Y    = 5'd13;
	localparam logic [4:0] KIND_SIZ_X    = 5'd14;
	localparam logic [4:0] KIND_SIZ_Y    = 5'd15;
	localparam logic [4:0] KIND_STORE    = 5'd16;

	// Screen line counts.
	localparam logic [16:0] LINES_LONG  = 17'd212;
	localparam logic [16:0] LINES_SHORT = 17'd192;

	// Mode codes.
	localparam logic [16:0] MODE_UNKNOWN = 17'd10;

	// One result record.
	typedef struct packed {
		logic        mem_write;
		logic [16:0] mem_address;
		logic [7:0]  mem_data;
		logic        palette_write;
		logic [3:0]  palette_index;
		logic [8:0]  palette_color;
		logic [4:0]  update_kind;
		logic [16:0] update_value;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/vppi_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vppi_stream_if
// Valid/ready channels of the port interface: the port write request and the
// result record.
// ----------------------------------------------------------------------------
interface vppi_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface vppi_res_if;
	logic        valid;
	logic        ready;
	logic        mem_write;
	logic [16:0] mem_address;
	logic [7:0]  mem_data;
	logic        palette_write;
	logic [3:0]  palette_index;
	logic [8:0]  palette_color;
	logic [4:0]  update_kind;
	logic [16:0] update_value;

	modport source (output valid, output mem_write, output mem_address, output mem_data,
		output palette_write, output palette_index, output palette_color,
		output update_kind, output update_value, input ready);
	modport sink   (input valid, input mem_write, input mem_address, input mem_data,
		input palette_write, input palette_index, input palette_color,
		input update_kind, input update_value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vppi_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vppi_core
// Port state (byte latch, address counter, the registers that are read back)
// and the combinational decode of one port write into its result record.
// ----------------------------------------------------------------------------
module vppi_core #(
	parameter int VRAM_ADDR_BITS = vppi_pkg::VRAM_ADDR_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire  [1:0]           command,
	input  wire  [7:0]           value,
	output vppi_pkg::result_t    res
);
	import vppi_pkg::*;

	typedef logic [VRAM_ADDR_BITS-1:0] addr_t;
	typedef logic [7:0] coord_t [12];

	// Only the registers that feed a later result are kept. A store to any
	// other index is reported but leaves nothing behind that is read again.
	logic       pend_q, pend_d;
	logic [7:0] latch_q, latch_d;
	addr_t      addr_q, addr_d;
	logic [7:0] mode0_q, mode0_d;
	logic [7:0] mode1_q, mode1_d;
	logic [7:0] pal_ptr_q, pal_ptr_d;
	coord_t     coord_q, coord_d;
	logic [4:0] mode_m;

	// Decode of one write and next state.
	always_comb begin
		res       = '0;
		pend_d    = pend_q;
		latch_d   = latch_q;
		addr_d    = addr_q;
		mode0_d   = mode0_q;
		mode1_d   = mode1_q;
		pal_ptr_d = pal_ptr_q;
		coord_d   = coord_q;
		mode_m    = '0;
		unique case (command)
			CMD_DATA: begin
				res.mem_write   = 1'b1;
				res.mem_address = 17'(addr_q);
				res.mem_data    = value;
				addr_d          = addr_q + addr_t'(1);
			end
			CMD_CONTROL: begin
				if (pend_q) begin
					pend_d = 1'b0;
					if (value[7]) begin
						res.update_kind  = KIND_STORE;
						res.update_value = 17'(latch_q);
						unique case (value[5:0])
							REG_MODE0, REG_MODE1: begin
								if (value[5:0] == REG_MODE1) begin
									mode1_d = latch_q;
								end else begin
									mode0_d = latch_q;
								end
								// Mode selection bits taken from the updated registers.
								mode_m = {mode0_d[3:1], mode1_d[3], mode1_d[4]};
								res.update_kind = KIND_MODE;
								unique case (mode_m)
									5'h01:   res.update_value = 17'd0;
									5'h00:   res.update_value = 17'd1;
									5'h04:   res.update_value = 17'd2;
									5'h02:   res.update_value = 17'd3;
									5'h08:   res.update_value = 17'd4;
									5'h0c:   res.update_value = 17'd5;
									5'h10:   res.update_value = 17'd6;
									5'h14:   res.update_value = 17'd7;
									5'h1c:   res.update_value = 17'd8;
									5'h09:   res.update_value = 17'd9;
									default: res.update_value = MODE_UNKNOWN;
								endcase
							end
							REG_NAME: begin
								res.update_kind  = KIND_NAME;
								res.update_value = {latch_q[6:0], 10'd0};
							end
							REG_COLOR: begin
								res.update_kind  = KIND_COLOR;
								res.update_value = {3'd0, latch_q, 6'd0};
							end
							REG_PATTERN: begin
								res.update_kind  = KIND_PATTERN;
								res.update_value = {latch_q[5:0], 11'd0};
							end
							REG_SPR_ATTR: begin
								res.update_kind  = KIND_SPR_ATTR;
								res.update_value = {2'd0, latch_q, 7'd0};
							end
							REG_SPR_PAT: begin
								res.update_kind  = KIND_SPR_PAT;
								res.update_value = {latch_q[5:0], 11'd0};
							end
							REG_BORDER: begin
								res.update_kind  = KIND_BORDER;
								res.update_value = {14'd0, latch_q[2:0]};
							end
							REG_LINES: begin
								res.update_kind  = KIND_LINES;
								res.update_value = latch_q[7] ? LINES_LONG : LINES_SHORT;
							end
							REG_SPR_COL: begin
								res.update_kind  = KIND_SPR_COL;
								res.update_value = {latch_q[1:0], 15'd0};
							end
							REG_ADDR_HI: begin
								// Upper address bits replace bits 16:14 of the counter.
								addr_d = addr_t'({latch_q[2:0], addr_q[13:0]});
								res.update_value = 17'(addr_d);
							end
							REG_PAL_PTR: begin
								pal_ptr_d = latch_q;
							end
							REG_SX_LO, REG_SX_HI: begin
								coord_d[value[3:0]] = latch_q;
								res.update_kind  = KIND_SRC_X;
								res.update_value = {8'd0, coord_d[REG_SX_HI[3:0]][0],
									coord_d[REG_SX_LO[3:0]]};
							end
							REG_SY_LO, REG_SY_HI: begin
								coord_d[value[3:0]] = latch_q;
								res.update_kind  = KIND_SRC_Y;
								res.update_value = {7'd0, coord_d[REG_SY_HI[3:0]][1:0],
									coord_d[REG_SY_LO[3:0]]};
							end
							REG_DX_LO, REG_DX_HI: begin
								coord_d[value[3:0]] = latch_q;
								res.update_kind  = KIND_DST_X;
								res.update_value = {8'd0, coord_d[REG_DX_HI[3:0]][0],
									coord_d[REG_DX_LO[3:0]]};
							end
							REG_DY_LO, REG_DY_HI: begin
								coord_d[value[3:0]] = latch_q;
								res.update_kind  = KIND_DST_Y;
								res.update_value = {7'd0, coord_d[REG_DY_HI[3:0]][1:0],
									coord_d[REG_DY_LO[3:0]]};
							end
							REG_NX_LO, REG_NX_HI: begin
								coord_d[value[3:0]] = latch_q;
								res.update_kind  = KIND_SIZ_X;
								res.update_value = {8'd0, coord_d[REG_NX_HI[3:0]][0],
									coord_d[REG_NX_LO[3:0]]};
							end
							REG_NY_LO, REG_NY_HI: begin
								coord_d[value[3:0]] = latch_q;
								res.update_kind  = KIND_SIZ_Y;
								res.update_value = {7'd0, coord_d[REG_NY_HI[3:0]][1:0],
									coord_d[REG_NY_LO[3:0]]};
							end
							default: begin
							end
						endcase
					end else begin
						// Address setup: 14-bit address, upper bits cleared.
						addr_d = addr_t'({value[5:0], latch_q});
					end
				end else begin
					latch_d = value;
					pend_d  = 1'b1;
				end
			end
			CMD_PALETTE: begin
				if (pend_q) begin
					pend_d              = 1'b0;
					res.palette_write   = 1'b1;
					res.palette_index   = pal_ptr_q[3:0];
					res.palette_color   = {latch_q[6:4], value[2:0], latch_q[2:0]};
					pal_ptr_d           = pal_ptr_q + 8'd1;
				end else begin
					latch_d = value;
					pend_d  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// State update on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			latch_q   <= '0;
			addr_q    <= '0;
			mode0_q   <= '0;
			mode1_q   <= '0;
			pal_ptr_q <= '0;
			coord_q   <= '{default: '0};
		end else if (accept) begin
			pend_q    <= pend_d;
			latch_q   <= latch_d;
			addr_q    <= addr_d;
			mode0_q   <= mode0_d;
			mode1_q   <= mode1_d;
			pal_ptr_q <= pal_ptr_d;
			coord_q   <= coord_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/vppi_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vppi_out_reg
// Result register: holds one result record until the receiver takes it and
// accepts a new one in the same cycle that the held one leaves.
// ----------------------------------------------------------------------------
module vppi_out_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  wire vppi_pkg::result_t res,
	output logic               space,
	vppi_res_if.source         result
);
	import vppi_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Room for a new record when empty or when the held one leaves now.
	assign space = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			data_q <= res;
		end
	end

	assign result.valid         = valid_q;
	assign result.mem_write     = data_q.mem_write;
	assign result.mem_address   = data_q.mem_address;
	assign result.mem_data      = data_q.mem_data;
	assign result.palette_write = data_q.palette_write;
	assign result.palette_index = data_q.palette_index;
	assign result.palette_color = data_q.palette_color;
	assign result.update_kind   = data_q.update_kind;
	assign result.update_value  = data_q.update_value;

endmodule
`default_nettype wire

// File: hw/rtl/video_processor_port_interface_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_processor_port_interface_top
// CPU port write interface of a video display processor.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries one CPU port write per transfer: a command
//   (data, control or palette port) and the byte written. The result channel
//   returns exactly one record per request: a video memory write, a palette
//   write, a register update report, or an all-zero record when the write only
//   latches a byte, loads the address or uses the unused command code.
//   The result is registered: a request taken in one cycle shows its result in
//   the cycle after. Throughput is one request per cycle while the result
//   channel does not stall; the core decodes each write combinationally and
//   updates state on transfer; the result register parts the two channels.
//   When the receiver stalls, the held result stays and one more request is
//   still taken in the cycle that result leaves; request ready is low only
//   while a result waits and result ready is low.
//   Reset clears the byte latch, the pending flag, the address counter, the
//   mode, palette pointer and command coordinate registers, and empties the
//   result register.
// ----------------------------------------------------------------------------
module video_processor_port_interface_top #(
	parameter int VRAM_ADDR_BITS = vppi_pkg::VRAM_ADDR_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	vppi_req_if.sink    request,
	vppi_res_if.source  result
);
	import vppi_pkg::*;

	logic    space;
	logic    accept;
	result_t res;

	// A request transfers whenever the result register has room.
	assign request.ready = space;
	assign accept        = request.valid && space;

	vppi_core #(
		.VRAM_ADDR_BITS(VRAM_ADDR_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (request.command),
		.value   (request.value),
		.res     (res)
	);

	vppi_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (request.valid),
		.res    (res),
		.space  (space),
		.result (result)
	);

endmodule
`default_nettype wire

// File: hw/rtl/vppi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vppi_checker
// Port-level checks of the video processor port interface, bound to the top.
// ----------------------------------------------------------------------------
module vppi_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire        mem_write,
	input wire        palette_write,
	input wire [4:0]  update_kind
);
	import vppi_pkg::*;

	// A held result stays until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Every request transfer shows a result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after request transfer");

	// Requests are refused only while a stalled result is held.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request refused without a stall");

	// A result is at most one kind of event.
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(mem_write && palette_write)
		&& ((!mem_write && !palette_write) || update_kind == KIND_NONE))
		else $error("result mixes event kinds");

endmodule

bind video_processor_port_interface_top vppi_checker u_vppi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (request.valid),
	.in_ready      (request.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.mem_write     (result.mem_write),
	.palette_write (result.palette_write),
	.update_kind   (result.update_kind)
);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the video processor port interface. Data, control
// and palette port writes go in through the request channel. A tracker class
// keeps its own copy of the byte latch, the address counter and the register
// file, and works out the record that each write should produce. Results are
// checked field by field, in order, while both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_top;
	import vppi_pkg::*;

	localparam int WRITE_TARGET = 1900;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLDOFF_LEN  = 80;

	// Command code that selects no port.
	localparam logic [1:0] CMD_NONE = 2'd3;

	// Tracks the port state and keeps the records that the block still owes.
	class port_write_tracker;
		result_t     owed_records[$];
		int unsigned mismatches;
		bit          pair_open;
		logic [7:0]  held_byte;
		logic [16:0] vram_addr;
		logic [7:0]  regs [64];

		function new();
			pair_open  = 1'b0;
			held_byte  = '0;
			vram_addr  = '0;
			mismatches = 0;
			foreach (regs[i])
				regs[i] = '0;
		endfunction

		// Applies one accepted port write and queues the record it causes.
		function void note_write(logic [1:0] cmd, logic [7:0] val);
			result_t     want;
			logic [5:0]  idx;
			logic [5:0]  lo_idx;
			logic [4:0]  mode_bits;
			logic [16:0] pair_val;
			want = '0;
			case (cmd)
				CMD_DATA: begin
					want.mem_write   = 1'b1;
					want.mem_address = vram_addr;
					want.mem_data    = val;
					vram_addr        = vram_addr + 17'd1;
				end
				CMD_CONTROL: begin
					if (!pair_open) begin
						held_byte = val;
						pair_open = 1'b1;
					end else begin
						pair_open = 1'b0;
						if (val[7]) begin
							// Register store: report the derived quantity.
							idx       = val[5:0];
							regs[idx] = held_byte;
							want.update_kind  = KIND_STORE;
							want.update_value = {9'd0, held_byte};
							case (idx)
								REG_MODE0, REG_MODE1: begin
									mode_bits = {regs[REG_MODE0][3:1], regs[REG_MODE1][3],
										regs[REG_MODE1][4]};
									want.update_kind = KIND_MODE;
									case (mode_bits)
										5'h01: want.update_value = 17'd0;
										5'h00: want.update_value = 17'd1;
										5'h04: want.update_value = 17'd2;
										5'h02: want.update_value = 17'd3;
										5'h08: want.update_value = 17'd4;
										5'h0c: want.update_value = 17'd5;
										5'h10: want.update_value = 17'd6;
										5'h14: want.update_value = 17'd7;
										5'h1c: want.update_value = 17'd8;
										5'h09: want.update_value = 17'd9;
										default: want.update_value = MODE_UNKNOWN;
									endcase
								end
								REG_NAME: begin
									want.update_kind  = KIND_NAME;
									want.update_value = {held_byte[6:0], 10'd0};
								end
								REG_COLOR: begin
									want.update_kind  = KIND_COLOR;
									want.update_value = {3'd0, held_byte, 6'd0};
								end
								REG_PATTERN: begin
									want.update_kind  = KIND_PATTERN;
									want.update_value = {held_byte[5:0], 11'd0};
								end
								REG_SPR_ATTR: begin
									want.update_kind  = KIND_SPR_ATTR;
									want.update_value = {2'd0, held_byte, 7'd0};
								end
								REG_SPR_PAT: begin
									want.update_kind  = KIND_SPR_PAT;
									want.update_value = {held_byte[5:0], 11'd0};
								end
								REG_BORDER: begin
									want.update_kind  = KIND_BORDER;
									want.update_value = {14'd0, held_byte[2:0]};
								end
								REG_LINES: begin
									want.update_kind  = KIND_LINES;
									want.update_value = held_byte[7] ? LINES_LONG : LINES_SHORT;
								end
								REG_SPR_COL: begin
									want.update_kind  = KIND_SPR_COL;
									want.update_value = {held_byte[1:0], 15'd0};
								end
								REG_ADDR_HI: begin
									vram_addr         = {held_byte[2:0], vram_addr[13:0]};
									want.update_value = vram_addr;
								end
								REG_SX_LO, REG_SX_HI, REG_SY_LO, REG_SY_HI,
								REG_DX_LO, REG_DX_HI, REG_DY_LO, REG_DY_HI,
								REG_NX_LO, REG_NX_HI, REG_NY_LO, REG_NY_HI: begin
									// Command coordinates: X pairs keep 9 bits, Y pairs 10.
									lo_idx   = {idx[5:1], 1'b0};
									pair_val = {1'b0, regs[lo_idx + 6'd1], regs[lo_idx]};
									want.update_kind  = KIND_SRC_X + 5'(idx[3:1]);
									want.update_value = pair_val & (idx[1] ? 17'h3ff : 17'h1ff);
								end
								default: ;
							endcase
						end else begin
							// Address setup clears the upper address bits.
							vram_addr = {3'd0, val[5:0], held_byte};
						end
					end
				end
				CMD_PALETTE: begin
					if (!pair_open) begin
						held_byte = val;
						pair_open = 1'b1;
					end else begin
						pair_open = 1'b0;
						want.palette_write = 1'b1;
						want.palette_index = regs[REG_PAL_PTR][3:0];
						want.palette_color = {held_byte[6:4], val[2:0], held_byte[2:0]};
						regs[REG_PAL_PTR]  = regs[REG_PAL_PTR] + 8'd1;
					end
				end
				default: ;
			endcase
			owed_records.push_back(want);
		endfunction

		// Compares one accepted record with the oldest owed one.
		function void check_record(result_t got);
			result_t want;
			if (owed_records.size() == 0) begin
				$error("result record with no write waiting: %p", got);
				mismatches++;
				return;
			end
			want = owed_records.pop_front();
			if (got.mem_write !== want.mem_write) begin
				$error("mem_write: expected %0h, actual %0h", want.mem_write, got.mem_write);
				mismatches++;
			end
			if (got.mem_address !== want.mem_address) begin
				$error("mem_address: expected %0h, actual %0h", want.mem_address,
					got.mem_address);
				mismatches++;
			end
			if (got.mem_data !== want.mem_data) begin
				$error("mem_data: expected %0h, actual %0h", want.mem_data, got.mem_data);
				mismatches++;
			end
			if (got.palette_write !== want.palette_write) begin
				$error("palette_write: expected %0h, actual %0h", want.palette_write,
					got.palette_write);
				mismatches++;
			end
			if (got.palette_index !== want.palette_index) begin
				$error("palette_index: expected %0h, actual %0h", want.palette_index,
					got.palette_index);
				mismatches++;
			end
			if (got.palette_color !== want.palette_color) begin
				$error("palette_color: expected %0h, actual %0h", want.palette_color,
					got.palette_color);
				mismatches++;
			end
			if (got.update_kind !== want.update_kind) begin
				$error("update_kind: expected %0d, actual %0d", want.update_kind,
					got.update_kind);
				mismatches++;
			end
			if (got.update_value !== want.update_value) begin
				$error("update_value: expected %0h, actual %0h", want.update_value,
					got.update_value);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	vppi_req_if req_ch ();
	vppi_res_if res_ch ();

	port_write_tracker tracker = new();

	int unsigned cycle_count   = 0;
	int unsigned writes_sent   = 0;
	int unsigned records_seen  = 0;
	bit          sender_quiet  = 1'b0;
	bit          receiver_quiet = 1'b0;
	bit          rx_holding    = 1'b0;

	video_processor_port_interface_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (res_ch)
	);

	// Clock.
	always #2 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offers one port write after a random gap and waits for its transfer.
	task automatic send_write(input logic [1:0] cmd, input logic [7:0] val);
		int unsigned gap;
		if (writes_sent % 50 == 0)
			sender_quiet = ($urandom_range(0, 2) == 0);
		gap = (sender_quiet || rx_holding) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value   <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_write(cmd, val);
		if (cmd != CMD_NONE)
			writes_sent++;
	endtask

	// Holds the sender, with nothing offered, until every owed record has come back.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (tracker.owed_records.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, two long hold-offs, one check per transfer.
	initial begin
		int unsigned gap;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (records_seen % 40 == 0)
				receiver_quiet = ($urandom_range(0, 2) == 0);
			gap = receiver_quiet ? 0 : $urandom_range(0, 18);
			if (records_seen == 400 || records_seen == 1300) begin
				gap        = HOLDOFF_LEN;
				rx_holding = 1'b1;
			end
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rx_holding = 1'b0;
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
			tracker.check_record({res_ch.mem_write, res_ch.mem_address, res_ch.mem_data,
				res_ch.palette_write, res_ch.palette_index, res_ch.palette_color,
				res_ch.update_kind, res_ch.update_value});
			records_seen++;
		end
	end

	// Request side: reset, directed writes, then random port sequences.
	initial begin
		logic [5:0] hot_regs [24] = '{REG_MODE0, REG_MODE1, REG_NAME, REG_COLOR,
			REG_PATTERN, REG_SPR_ATTR, REG_SPR_PAT, REG_BORDER, REG_LINES, REG_SPR_COL,
			REG_ADDR_HI, REG_PAL_PTR, REG_SX_LO, REG_SX_HI, REG_SY_LO, REG_SY_HI,
			REG_DX_LO, REG_DX_HI, REG_DY_LO, REG_DY_HI, REG_NX_LO, REG_NX_HI,
			REG_NY_LO, REG_NY_HI};
		logic [5:0]  reg_idx;
		int unsigned pick;
		int unsigned burst;
		bit          paused = 1'b0;

		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.command <= CMD_DATA;
		req_ch.value   <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Data bytes at the extremes, and an unused command code.
		send_write(CMD_DATA, 8'h00);
		send_write(CMD_DATA, 8'hff);
		send_write(CMD_NONE, 8'hff);
		// Low address bits all ones, then upper bits all ones: the data write
		// lands on the top address and the next one wraps to zero.
		send_write(CMD_CONTROL, 8'hff);
		send_write(CMD_CONTROL, 8'h3f);
		send_write(CMD_CONTROL, 8'h07);
		send_write(CMD_CONTROL, {2'b10, REG_ADDR_HI});
		send_write(CMD_DATA, 8'ha5);
		send_write(CMD_DATA, 8'h5a);
		// Palette pointer at 15; two palette pairs cross the index wrap.
		send_write(CMD_CONTROL, 8'h0f);
		send_write(CMD_CONTROL, {2'b10, REG_PAL_PTR});
		send_write(CMD_PALETTE, 8'h77);
		send_write(CMD_PALETTE, 8'h07);
		send_write(CMD_PALETTE, 8'h00);
		send_write(CMD_PALETTE, 8'h00);
		// Register store with the read/write flag set, and a mode register.
		send_write(CMD_CONTROL, 8'h80);
		send_write(CMD_CONTROL, {2'b11, REG_LINES});
		send_write(CMD_CONTROL, 8'h0e);
		send_write(CMD_CONTROL, {2'b10, REG_MODE0});
		// Address setup with the read/write flag set.
		send_write(CMD_CONTROL, 8'hff);
		send_write(CMD_CONTROL, 8'h40);
		// The latch is shared: a control byte followed by a palette byte.
		send_write(CMD_CONTROL, 8'hff);
		send_write(CMD_PALETTE, 8'hff);
		// Top command coordinate register.
		send_write(CMD_CONTROL, 8'h01);
		send_write(CMD_CONTROL, {2'b10, REG_NY_HI});
		drain_results();

		// Random port sequences, mostly well formed, with some noise.
		while (writes_sent < WRITE_TARGET) begin
			if (!paused && writes_sent >= WRITE_TARGET / 2) begin
				paused = 1'b1;
				drain_results();
			end
			pick = $urandom_range(0, 9);
			if (pick <= 2) begin
				burst = $urandom_range(1, 4);
				repeat (burst) send_write(CMD_DATA, 8'($urandom));
			end else if (pick <= 5) begin
				reg_idx = $urandom_range(0, 1) ? hot_regs[$urandom_range(0, 23)]
					: 6'($urandom);
				send_write(CMD_CONTROL, 8'($urandom));
				send_write(CMD_CONTROL, {1'b1, 1'($urandom), reg_idx});
			end else if (pick == 6) begin
				send_write(CMD_CONTROL, 8'($urandom));
				send_write(CMD_CONTROL, {1'b0, 7'($urandom)});
			end else if (pick <= 8) begin
				send_write(CMD_PALETTE, 8'($urandom));
				send_write(CMD_PALETTE, 8'($urandom));
			end else begin
				send_write(2'($urandom_range(0, 3)), 8'($urandom));
			end
		end
		req_ch.valid <= 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/vppi_pkg.sv
hw/rtl/vppi_stream_if.sv
hw/rtl/vppi_core.sv
hw/rtl/vppi_out_reg.sv
hw/rtl/video_processor_port_interface_top.sv
hw/rtl/vppi_checker.sv
tb/tb_top.sv
